// ===== rtl/core/cell_frame_packer_crc8_defines.svh =====
// Assertion helpers; the user module must have aclk and aresetn.
`ifndef CELL_FRAME_PACKER_CRC8_DEFINES_SVH
`define CELL_FRAME_PACKER_CRC8_DEFINES_SVH

// Combinational property checked on every clock outside reset.
`define CFP_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define CFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/cfp_pkg.sv =====
package cfp_pkg;

    localparam int S_TDATA_W  = 64;
    localparam int FRAME_LEN  = 10;
    localparam int DATA_BYTES = FRAME_LEN - 1;
    localparam int IDX_W      = $clog2(FRAME_LEN);
    localparam int NUM_SLOTS  = 5;
    localparam int READING_W  = 10;
    localparam int LINE_W     = 5;

    localparam logic [7:0]       CRC_POLY = 8'h8D;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

    typedef logic [7:0] byte_t;
    typedef byte_t [DATA_BYTES-1:0] frame_t;

    typedef enum logic [1:0] {
        REG_VOLT_ID    = 2'd0,
        REG_TEMP_ID    = 2'd1,
        REG_VOLT_COUNT = 2'd2,
        REG_TEMP_COUNT = 2'd3
    } reg_idx_t;

    typedef struct packed {
        byte_t       voltage_frame_id;
        byte_t       temperature_frame_id;
        logic [5:0]  voltage_slot_count;
        logic [7:0]  temperature_slot_count;
    } cfg_t;

    // One byte through the MSB-first CRC-8 shift register.
    function automatic byte_t crc8_byte(input byte_t crc_in, input byte_t data);
        byte_t c;
        c = crc_in ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/cfp_pack.sv =====
module cfp_pack (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  cfp_pkg::cfg_t                   cfg,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [cfp_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            s_tuser,
    output logic                            frm_valid,
    input  logic                            frm_ready,
    output cfp_pkg::frame_t                 frm_data
);
    import cfp_pkg::*;

    logic                 frm_valid_reg;
    logic                 frm_valid_next;
    frame_t               frame_reg;
    frame_t               frame_next;

    logic [LINE_W-1:0]    line;
    logic [7:0]           count;
    logic [7:0]           base;
    logic [READING_W-1:0] rd [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] flt;
    logic [7:0]           flags;
    logic [7:0]           slot;

    assign line = s_tdata[LINE_W-1:0];
    assign count = s_tuser ? cfg.temperature_slot_count : {2'b00, cfg.voltage_slot_count};
    assign base = {1'b0, line, 2'b00} + {3'b000, line};

    always_comb begin
        flags = 8'h00;
        slot  = 8'h00;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            slot = base + 8'(k);
            if (slot < count) begin
                rd[k]  = s_tdata[LINE_W + k*READING_W +: READING_W];
                flt[k] = s_tdata[LINE_W + NUM_SLOTS*READING_W + k];
            end else begin
                rd[k]  = '0;
                flt[k] = 1'b0;
            end
            flags[7-k] = flt[k];
        end
    end

    always_comb begin
        if (s_tuser) begin
            frame_next[0] = cfg.temperature_frame_id;
            frame_next[1] = flags | {5'b00000, line[4:2]};
            frame_next[2] = {line[1:0], 4'b0000, rd[0][9:8]};
        end else begin
            frame_next[0] = cfg.voltage_frame_id;
            frame_next[1] = flags | {3'b000, line};
            frame_next[2] = {6'b000000, rd[0][9:8]};
        end
        frame_next[3] = rd[0][7:0];
        frame_next[4] = rd[1][9:2];
        frame_next[5] = {rd[1][1:0], rd[2][9:4]};
        frame_next[6] = {rd[2][3:0], rd[3][9:6]};
        frame_next[7] = {rd[3][5:0], rd[4][9:8]};
        frame_next[8] = rd[4][7:0];
    end

    assign s_tready = !frm_valid_reg || frm_ready;

    always_comb begin
        frm_valid_next = frm_valid_reg;
        if (s_tvalid && s_tready) begin
            frm_valid_next = 1'b1;
        end else if (frm_ready) begin
            frm_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frm_valid_reg <= 1'b0;
        end else begin
            frm_valid_reg <= frm_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            frame_reg <= frame_next;
        end
    end

    assign frm_valid = frm_valid_reg;
    assign frm_data  = frame_reg;

endmodule

// ===== rtl/core/cfp_ser.sv =====
`include "cell_frame_packer_crc8_defines.svh"

module cfp_ser (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            frm_valid,
    output logic            frm_ready,
    input  cfp_pkg::frame_t frm_data,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,
    output logic            m_tlast
);
    import cfp_pkg::*;

    logic             busy_reg;
    logic             busy_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    byte_t            crc_reg;
    byte_t            crc_next;
    frame_t           frame_reg;
    byte_t            cur_byte;
    logic             take;
    logic             at_last;

    assign at_last = (idx_reg == LAST_IDX);
    assign take    = busy_reg && m_tready;

    always_comb begin
        if (at_last) begin
            cur_byte = crc_reg;
        end else begin
            cur_byte = frame_reg[idx_reg];
        end
    end

    assign frm_ready = !busy_reg || (take && at_last);

    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        crc_next  = crc_reg;
        if (frm_valid && frm_ready) begin
            busy_next = 1'b1;
            idx_next  = '0;
            crc_next  = 8'h00;
        end else if (take) begin
            if (at_last) begin
                busy_next = 1'b0;
            end else begin
                idx_next = idx_reg + 1'b1;
                crc_next = crc8_byte(crc_reg, cur_byte);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            crc_reg  <= 8'h00;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            crc_reg  <= crc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (frm_valid && frm_ready) begin
            frame_reg <= frm_data;
        end
    end

    assign m_tvalid = busy_reg;
    assign m_tdata  = cur_byte;
    assign m_tlast  = at_last;

    `CFP_ASSERT(a_idx_range, !busy_reg || idx_reg <= LAST_IDX, "byte index out of range")
    `CFP_ASSERT_NEXT(a_mid_frame, take && !at_last, m_tvalid && idx_reg == $past(idx_reg) + 1'b1,
        "frame cut short")
    `CFP_ASSERT_NEXT(a_end_idle, take && at_last && !frm_valid, !m_tvalid,
        "word shown after frame end")
    `CFP_ASSERT_NEXT(a_load_start, frm_valid && frm_ready,
        m_tvalid && idx_reg == '0 && crc_reg == 8'h00, "frame load did not restart")

endmodule

// ===== rtl/core/cell_frame_packer_crc8.sv =====
// Cell frame packer with CRC-8 (poly 0x8D, init 0).
// Input channel s_*: one word is one line of five 10-bit readings, their
// fault flags and a line index; s_tuser selects voltage (0) or temperature (1).
// Output channel m_*: each input word becomes ten one-byte words; m_tlast
// marks the tenth, the CRC over the first nine.
// Config port: cfg_wr_en/cfg_addr/cfg_wdata, index 0 voltage id, 1 temperature
// id, 2 voltage slot count (low 6 bits), 3 temperature slot count. Write only
// while the block is idle.
// A taken input word is registered in the packer's frame buffer, then loaded
// into the byte serializer, which shows its first byte. The input word rate is
// set by the byte serializer, which sends one byte per cycle while m_tready is
// high and folds it into the CRC register as it goes. One packed frame waits
// in a buffer, so the next word is taken while the current frame is still
// going out and frames follow with no gap.
// Reset (aresetn low, synchronous): pipeline empty, ids 0, counts 40 and 160.
// A stalled m_tready holds the current byte; once the buffer is full as well,
// s_tready drops.
module cell_frame_packer_crc8 (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // line_index[4:0], reading_a..reading_e[54:5], fault_a..fault_e[59:55], zero pad
    input  logic [63:0] s_tdata,
    // cmd
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // frame_byte
    output logic [7:0]  m_tdata,
    output logic        m_tlast
);
    import cfp_pkg::*;

    cfg_t   cfg_reg;
    cfg_t   cfg_next;
    logic   frm_valid;
    logic   frm_ready;
    frame_t frm_data;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (reg_idx_t'(cfg_addr))
                REG_VOLT_ID:    cfg_next.voltage_frame_id       = cfg_wdata;
                REG_TEMP_ID:    cfg_next.temperature_frame_id   = cfg_wdata;
                REG_VOLT_COUNT: cfg_next.voltage_slot_count     = cfg_wdata[5:0];
                REG_TEMP_COUNT: cfg_next.temperature_slot_count = cfg_wdata;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.voltage_frame_id       <= 8'd0;
            cfg_reg.temperature_frame_id   <= 8'd0;
            cfg_reg.voltage_slot_count     <= 6'd40;
            cfg_reg.temperature_slot_count <= 8'd160;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    cfp_pack u_pack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .frm_valid (frm_valid),
        .frm_ready (frm_ready),
        .frm_data  (frm_data)
    );

    cfp_ser u_ser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .frm_valid (frm_valid),
        .frm_ready (frm_ready),
        .frm_data  (frm_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
